>>> rtl/core/cbd_pkg.sv
// package for the chunked body decoder: item types, phase and kind codes
// and the byte classification function; no dependencies
`timescale 1ns / 1ps

package cbd_pkg;

   localparam int SIZE_BITS = 32;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       restart;
   } req_type;

   typedef enum logic [2:0] {
      KIND_FRAME   = 3'd0,
      KIND_PAYLOAD = 3'd1,
      KIND_DONE    = 3'd2,
      KIND_ERROR   = 3'd3,
      KIND_IGNORED = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload;
      logic       chunk_end;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_SIZE     = 4'd0,
      PH_SIZE_LF  = 4'd1,
      PH_DATA     = 4'd2,
      PH_DATA_CR  = 4'd3,
      PH_DATA_LF  = 4'd4,
      PH_FINAL_CR = 4'd5,
      PH_FINAL_LF = 4'd6,
      PH_DONE     = 4'd7,
      PH_ERROR    = 4'd8
   } phase_type;

   // byte after classification, as it travels from front to back
   typedef struct packed {
      logic [7:0] body_byte;
      logic       restart;
      logic       is_cr;
      logic       is_lf;
      logic       is_blank;
      logic       is_hex;
      logic [3:0] hex_val;
   } item_type;

   function automatic item_type classify(input req_type req);
      item_type   it;
      logic [7:0] c;
      c = req.body_byte;
      it.body_byte = c;
      it.restart   = req.restart;
      it.is_cr     = (c == CH_CR);
      it.is_lf     = (c == CH_LF);
      it.is_blank  = (c == CH_SPACE) || (c == CH_TAB);
      it.is_hex    = 1'b1;
      it.hex_val   = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         it.hex_val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         it.hex_val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         it.hex_val = 4'(c - 8'h37);
      end else begin
         it.is_hex = 1'b0;
      end
      return it;
   endfunction

endpackage

>>> rtl/core/cbd_front.sv
// front stage: takes request bytes, classifies them and holds one item
// for the queue; depends on cbd_pkg
`timescale 1ns / 1ps

module cbd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbd_pkg::req_type  req_data,
   output logic              item_valid,
   input  logic              item_ready,
   output cbd_pkg::item_type item_data
);

   logic              valid_ff;
   logic              valid_in;
   cbd_pkg::item_type item_ff;

   assign req_ready  = !valid_ff || item_ready;
   assign item_valid = valid_ff;
   assign item_data  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= cbd_pkg::classify(req_data);
      end
   end

endmodule

>>> rtl/core/cbd_queue.sv
// two-entry queue of classified items between front and back stages;
// depends on cbd_pkg
`timescale 1ns / 1ps

module cbd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  cbd_pkg::item_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output cbd_pkg::item_type rd_data
);

   cbd_pkg::item_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              do_wr;
   logic              do_rd;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/core/cbd_back.sv
// back stage: framing state machine, chunk size counter and result
// register; depends on cbd_pkg
`timescale 1ns / 1ps

module cbd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  cbd_pkg::item_type item_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbd_pkg::rsp_type  rsp_data
);

   localparam int SB = cbd_pkg::SIZE_BITS;

   cbd_pkg::phase_type phase_ff;
   cbd_pkg::phase_type phase_in;
   logic [SB-1:0]      remaining_ff;
   logic [SB-1:0]      remaining_in;
   logic               digit_seen_ff;
   logic               digit_seen_in;
   logic               digits_closed_ff;
   logic               digits_closed_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   cbd_pkg::rsp_type   out_ff;
   cbd_pkg::rsp_type   out_in;

   // state as seen by this item, after an optional restart
   cbd_pkg::phase_type cur_phase;
   logic [SB-1:0]      cur_rem;
   logic               cur_seen;
   logic               cur_closed;
   logic               take;
   logic               overflow;
   logic               rem_is_one;

   assign item_ready = !out_valid_ff || rsp_ready;
   assign take       = item_valid && item_ready;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;

   always_comb begin
      cur_phase  = item_data.restart ? cbd_pkg::PH_SIZE : phase_ff;
      cur_rem    = item_data.restart ? '0 : remaining_ff;
      cur_seen   = item_data.restart ? 1'b0 : digit_seen_ff;
      cur_closed = item_data.restart ? 1'b0 : digits_closed_ff;
      overflow   = (cur_rem[SB-1 -: 4] != 4'd0);
      rem_is_one = (cur_rem == SB'(1));
   end

   // next state
   always_comb begin
      phase_in         = cur_phase;
      remaining_in     = cur_rem;
      digit_seen_in    = cur_seen;
      digits_closed_in = cur_closed;
      unique case (cur_phase)
         cbd_pkg::PH_SIZE: begin
            if (item_data.is_cr) begin
               phase_in = cur_seen ? cbd_pkg::PH_SIZE_LF : cbd_pkg::PH_ERROR;
            end else if (!cur_seen && item_data.is_blank) begin
               phase_in = cur_phase;
            end else if (!cur_seen && !item_data.is_hex) begin
               phase_in = cbd_pkg::PH_ERROR;
            end else if (item_data.is_hex && !cur_closed) begin
               if (overflow) begin
                  phase_in = cbd_pkg::PH_ERROR;
               end else begin
                  remaining_in  = {cur_rem[SB-5:0], item_data.hex_val};
                  digit_seen_in = 1'b1;
               end
            end else begin
               digits_closed_in = 1'b1;
            end
         end
         cbd_pkg::PH_SIZE_LF: begin
            if (!item_data.is_lf) begin
               phase_in = cbd_pkg::PH_ERROR;
            end else begin
               digit_seen_in    = 1'b0;
               digits_closed_in = 1'b0;
               phase_in = (cur_rem == '0) ? cbd_pkg::PH_FINAL_CR : cbd_pkg::PH_DATA;
            end
         end
         cbd_pkg::PH_DATA: begin
            remaining_in = cur_rem - SB'(1);
            if (rem_is_one) begin
               phase_in = cbd_pkg::PH_DATA_CR;
            end
         end
         cbd_pkg::PH_DATA_CR: begin
            phase_in = item_data.is_cr ? cbd_pkg::PH_DATA_LF : cbd_pkg::PH_ERROR;
         end
         cbd_pkg::PH_DATA_LF: begin
            phase_in = item_data.is_lf ? cbd_pkg::PH_SIZE : cbd_pkg::PH_ERROR;
         end
         cbd_pkg::PH_FINAL_CR: begin
            phase_in = item_data.is_cr ? cbd_pkg::PH_FINAL_LF : cbd_pkg::PH_ERROR;
         end
         cbd_pkg::PH_FINAL_LF: begin
            phase_in = item_data.is_lf ? cbd_pkg::PH_DONE : cbd_pkg::PH_ERROR;
         end
         default: begin
            phase_in = cur_phase;
         end
      endcase
   end

   // result for this item
   always_comb begin
      out_in.kind      = cbd_pkg::KIND_FRAME;
      out_in.payload   = 8'd0;
      out_in.chunk_end = 1'b0;
      unique case (cur_phase) inside
         cbd_pkg::PH_SIZE: begin
            if (item_data.is_cr) begin
               if (!cur_seen) out_in.kind = cbd_pkg::KIND_ERROR;
            end else if (!cur_seen && item_data.is_blank) begin
               out_in.kind = cbd_pkg::KIND_FRAME;
            end else if (!cur_seen && !item_data.is_hex) begin
               out_in.kind = cbd_pkg::KIND_ERROR;
            end else if (item_data.is_hex && !cur_closed && overflow) begin
               out_in.kind = cbd_pkg::KIND_ERROR;
            end
         end
         cbd_pkg::PH_SIZE_LF, cbd_pkg::PH_DATA_LF: begin
            if (!item_data.is_lf) out_in.kind = cbd_pkg::KIND_ERROR;
         end
         cbd_pkg::PH_DATA: begin
            out_in.kind      = cbd_pkg::KIND_PAYLOAD;
            out_in.payload   = item_data.body_byte;
            out_in.chunk_end = rem_is_one;
         end
         cbd_pkg::PH_DATA_CR, cbd_pkg::PH_FINAL_CR: begin
            if (!item_data.is_cr) out_in.kind = cbd_pkg::KIND_ERROR;
         end
         cbd_pkg::PH_FINAL_LF: begin
            out_in.kind = item_data.is_lf ? cbd_pkg::KIND_DONE : cbd_pkg::KIND_ERROR;
         end
         default: begin
            out_in.kind = cbd_pkg::KIND_IGNORED;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (item_ready) begin
         out_valid_in = item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= cbd_pkg::PH_SIZE;
         remaining_ff     <= '0;
         digit_seen_ff    <= 1'b0;
         digits_closed_ff <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff         <= phase_in;
            remaining_ff     <= remaining_in;
            digit_seen_ff    <= digit_seen_in;
            digits_closed_ff <= digits_closed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= out_in;
      end
   end

endmodule

>>> rtl/core/chunked_body_decoder.sv
// chunked body decoder top level: front classifier, item queue and back
// state machine; depends on cbd_pkg, cbd_front, cbd_queue, cbd_back
//
// Usage: body bytes of a chunked message enter on req_valid/req_ready with
// req_data (body_byte, restart). Every accepted byte gives exactly one
// result on rsp_valid/rsp_ready with rsp_data (kind, payload, chunk_end):
// framing consumed, payload byte, body complete, error or ignored. Setting
// restart with a byte clears the decoder before that byte is handled.
// After body complete or an error every byte is ignored until restart.
// Throughput is one byte per clock while the receiver keeps rsp_ready
// high; the size counter update and the phase step are both
// combinational in the back stage. With the pipe empty an accepted byte
// passes the front register, then a queue entry, then the result
// register before rsp_valid rises.
// Reset empties the front register, the queue and the result register and
// puts the decoder at the start of a size line. When the receiver holds
// rsp_ready low the result register keeps its item, the back stage stops,
// the two-entry queue and the front register fill, and then req_ready
// drops; no item is lost or repeated.
`timescale 1ns / 1ps

module chunked_body_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cbd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cbd_pkg::rsp_type rsp_data
);

   logic              front_valid;
   logic              front_ready;
   cbd_pkg::item_type front_item;
   logic              queue_valid;
   logic              queue_ready;
   cbd_pkg::item_type queue_item;

   cbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item_data  (front_item)
   );

   cbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_data  (front_item),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready),
      .rd_data  (queue_item)
   );

   cbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item_data  (queue_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> sim/chunked_body_decoder_check.sv
// checker for the chunked body decoder: predicts one result per accepted item
// and compares results in order; depends on cbd_pkg
`timescale 1ns / 1ps

module chunked_body_decoder_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cbd_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cbd_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);

   cbd_pkg::phase_type            cur_phase;
   logic [cbd_pkg::SIZE_BITS-1:0] size_left;
   logic                          have_digit;
   logic                          size_closed;
   cbd_pkg::rsp_type              result_q[$];
   int                            fails = 0;

   assign fail_count = fails;

   task automatic report(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      fails++;
   endtask

   function automatic void clear_state();
      cur_phase   = cbd_pkg::PH_SIZE;
      size_left   = '0;
      have_digit  = 1'b0;
      size_closed = 1'b0;
   endfunction

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - 8'h30);
      if (c >= "a" && c <= "f") return int'(c - 8'h57);
      if (c >= "A" && c <= "F") return int'(c - 8'h37);
      return -1;
   endfunction

   // advances the decoder state by one byte and returns its result
   function automatic cbd_pkg::rsp_type decode_byte(input cbd_pkg::req_type req);
      cbd_pkg::rsp_type res;
      logic [7:0]       c;
      int               d;
      c             = req.body_byte;
      res.kind      = cbd_pkg::KIND_FRAME;
      res.payload   = 8'd0;
      res.chunk_end = 1'b0;
      if (req.restart) clear_state();
      d = hex_value(c);
      case (cur_phase)
         cbd_pkg::PH_SIZE: begin
            if (c == cbd_pkg::CH_CR) begin
               if (!have_digit) res.kind = cbd_pkg::KIND_ERROR;
               else cur_phase = cbd_pkg::PH_SIZE_LF;
            end else if (!have_digit && (c == cbd_pkg::CH_SPACE ||
                                         c == cbd_pkg::CH_TAB)) begin
               res.kind = cbd_pkg::KIND_FRAME;
            end else if (!have_digit && d < 0) begin
               res.kind = cbd_pkg::KIND_ERROR;
            end else if (d >= 0 && !size_closed) begin
               // another digit must not push the size past the counter
               if (size_left[cbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
                  res.kind = cbd_pkg::KIND_ERROR;
               end else begin
                  size_left  = {size_left[cbd_pkg::SIZE_BITS-5:0], 4'(d)};
                  have_digit = 1'b1;
               end
            end else begin
               size_closed = 1'b1;
            end
         end
         cbd_pkg::PH_SIZE_LF: begin
            if (c != cbd_pkg::CH_LF) begin
               res.kind = cbd_pkg::KIND_ERROR;
            end else begin
               have_digit  = 1'b0;
               size_closed = 1'b0;
               cur_phase   = (size_left == '0) ? cbd_pkg::PH_FINAL_CR : cbd_pkg::PH_DATA;
            end
         end
         cbd_pkg::PH_DATA: begin
            res.kind    = cbd_pkg::KIND_PAYLOAD;
            res.payload = c;
            size_left   = size_left - 1'b1;
            if (size_left == '0) begin
               res.chunk_end = 1'b1;
               cur_phase     = cbd_pkg::PH_DATA_CR;
            end
         end
         cbd_pkg::PH_DATA_CR: begin
            if (c != cbd_pkg::CH_CR) res.kind = cbd_pkg::KIND_ERROR;
            else cur_phase = cbd_pkg::PH_DATA_LF;
         end
         cbd_pkg::PH_DATA_LF: begin
            if (c != cbd_pkg::CH_LF) res.kind = cbd_pkg::KIND_ERROR;
            else cur_phase = cbd_pkg::PH_SIZE;
         end
         cbd_pkg::PH_FINAL_CR: begin
            if (c != cbd_pkg::CH_CR) res.kind = cbd_pkg::KIND_ERROR;
            else cur_phase = cbd_pkg::PH_FINAL_LF;
         end
         cbd_pkg::PH_FINAL_LF: begin
            if (c != cbd_pkg::CH_LF) begin
               res.kind = cbd_pkg::KIND_ERROR;
            end else begin
               res.kind  = cbd_pkg::KIND_DONE;
               cur_phase = cbd_pkg::PH_DONE;
            end
         end
         default: begin
            res.kind = cbd_pkg::KIND_IGNORED;
         end
      endcase
      if (res.kind == cbd_pkg::KIND_ERROR) cur_phase = cbd_pkg::PH_ERROR;
      return res;
   endfunction

   always @(posedge clock) begin
      cbd_pkg::rsp_type want;
      if (reset) begin
         clear_state();
         result_q.delete();
      end else begin
         if (req_valid && req_ready) result_q.push_back(decode_byte(req_data));
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               report($sformatf("result with no item waiting, kind %0d",
                                rsp_data.kind));
            end else begin
               want = result_q.pop_front();
               if (rsp_data.kind !== want.kind) begin
                  report($sformatf("kind %0d, expected %0d", rsp_data.kind, want.kind));
               end
               if (rsp_data.payload !== want.payload) begin
                  report($sformatf("payload %h, expected %h", rsp_data.payload,
                                   want.payload));
               end
               if (rsp_data.chunk_end !== want.chunk_end) begin
                  report($sformatf("chunk_end %b, expected %b", rsp_data.chunk_end,
                                   want.chunk_end));
               end
            end
         end
      end
      pending <= result_q.size();
   end

endmodule

>>> sim/chunked_body_decoder_test.sv
// top of the chunked body decoder test: clock, reset, chunked body stimulus,
// receiver stalls and verdict; depends on cbd_pkg, the block and its checker
`timescale 1ns / 1ps

module chunked_body_decoder_test;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int BYTE_TARGET  = 900;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   cbd_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   cbd_pkg::rsp_type rsp_data;

   int               fail_count;
   int               pending;
   int               idle_cycles = 0;
   int               hold_mode   = 0;
   int               hold_left   = 0;
   cbd_pkg::req_type body_q[$];

   always #6 clock = ~clock;

   chunked_body_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   chunked_body_decoder_check i_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   task automatic push_byte(input logic [7:0] b, input bit rst);
      cbd_pkg::req_type item;
      item.body_byte = b;
      item.restart   = rst;
      body_q.push_back(item);
   endtask

   task automatic push_text(input string s, input bit rst);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(s[i], rst && i == 0);
      end
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   // size line: optional blanks, leading zeros and extension, then cr lf
   task automatic push_size_line(input logic [31:0] value, input bit rst);
      string      ext_lead;
      int         ndig;
      int         zeros;
      bit         first;
      logic [7:0] b;
      ext_lead = "; =x\n\tzG";
      first    = rst;
      ndig     = 8;
      while (ndig > 1 && value[4*ndig-1 -: 4] == 4'd0) ndig--;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            push_byte($urandom_range(0, 1) ? cbd_pkg::CH_SPACE : cbd_pkg::CH_TAB, first);
            first = 1'b0;
         end
      end
      zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      repeat (zeros) begin
         push_byte("0", first);
         first = 1'b0;
      end
      for (int i = ndig - 1; i >= 0; i--) begin
         push_byte(hex_char(value[4*i +: 4]), first);
         first = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
         push_byte(ext_lead[$urandom_range(0, ext_lead.len() - 1)], 1'b0);
         repeat ($urandom_range(0, 4)) begin
            b = 8'($urandom_range(0, 255));
            push_byte((b == cbd_pkg::CH_CR) ? 8'h78 : b, 1'b0);
         end
      end
      push_byte(cbd_pkg::CH_CR, 1'b0);
      push_byte(cbd_pkg::CH_LF, 1'b0);
   endtask

   // receiver: segments of always ready, random, full stall and sparse ready
   always @(posedge clock) begin
      if (hold_left == 0) begin
         hold_mode <= $urandom_range(0, 3);
         hold_left <= $urandom_range(1, 40);
      end else begin
         hold_left <= hold_left - 1;
      end
      case (hold_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= 1'b0;
         default: rsp_ready <= (hold_left % 3 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          idx;
      int          burst;
      int          gap;
      int          pick;
      int          nchunks;
      int          size;
      int          start;
      int          pos;
      bit          first;
      logic [31:0] big;

      // blanks, extension with a late hex digit and bare lf, extreme payload
      push_text(" \t2;F\n\r\n", 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_text("\r\n0\r\n\r\n", 1'b0);
      push_text("x", 1'b0);
      // no digits, then ignored until restart
      push_text("g", 1'b1);
      push_text("a", 1'b0);
      push_text("\r", 1'b1);
      push_text("1\rx", 1'b1);
      push_text("1\r\nAz", 1'b1);

      while (body_q.size() < BYTE_TARGET) begin
         pick  = $urandom_range(0, 99);
         start = body_q.size();
         if (pick < 8) begin
            repeat ($urandom_range(1, 6)) begin
               push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
         end else if (pick < 12) begin
            // size that overflows the counter
            push_byte(hex_char(4'($urandom_range(1, 15))), 1'b1);
            repeat ($urandom_range(8, 10)) push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
         end else if (pick < 15) begin
            // huge chunk cut short by a restart in the next body
            big     = $urandom();
            big[31] = 1'b1;
            push_size_line(big, 1'b1);
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            nchunks = $urandom_range(0, 3);
            first   = 1'b1;
            repeat (nchunks) begin
               size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
               push_size_line(32'(size), first);
               first = 1'b0;
               repeat (size) push_byte(8'($urandom_range(0, 255)), 1'b0);
               push_byte(cbd_pkg::CH_CR, 1'b0);
               push_byte(cbd_pkg::CH_LF, 1'b0);
            end
            push_size_line(32'd0, first);
            push_byte(cbd_pkg::CH_CR, 1'b0);
            push_byte(cbd_pkg::CH_LF, 1'b0);
            if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(0, 255)), 1'b0);
            // broken bodies: a corrupted byte or a restart in the middle
            if (pick >= 80) begin
               pos = $urandom_range(start, body_q.size() - 1);
               if (pick >= 94) body_q[pos].restart = 1'b1;
               else body_q[pos].body_byte = 8'($urandom_range(0, 255));
            end
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      idx = 0;
      while (idx < body_q.size()) begin
         burst = $urandom_range(1, 48);
         while (burst > 0 && idx < body_q.size()) begin
            req_valid <= 1'b1;
            req_data  <= body_q[idx];
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            idx++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
